### rtl/core/image_convolution_2d_same_assert.svh
// assertion macros shared by the convolution block
`ifndef IMAGE_CONVOLUTION_2D_SAME_ASSERT_SVH
`define IMAGE_CONVOLUTION_2D_SAME_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ICS2D_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define ICS2D_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/ics2d_pkg.sv
// shared types and constants of the zero-padded 2-d convolution block
package ics2d_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_KERNEL  = 5;
    localparam int TAP_ROWS    = 5;
    localparam int RING_ROWS   = MAX_KERNEL + 1;
    localparam int SLOT_W      = $clog2(RING_ROWS);
    localparam int SAMPLE_W    = 16;
    localparam int TAP_W       = 12;
    localparam int PROD_W      = SAMPLE_W + TAP_W;
    localparam int RSUM_W      = PROD_W + 3;
    localparam int RESULT_W    = 40;
    localparam int ROW_W       = 16;
    localparam int ROW_CNT_W   = ROW_W + 1;
    localparam int COL_OUT_W   = 10;
    localparam int CFG_W       = 60;
    localparam int CFG_IDX_W   = 3;
    localparam int WIDTH_REG_W = 11;
    localparam int KSIZE_REG_W = 3;
    localparam int OFIFO_DEPTH = 8;
    localparam int OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
    localparam int OFIFO_CNT_W = OFIFO_PTR_W + 1;
    localparam int PEND_STAGES = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_KERNEL_SIZE  = 3'd2,
        CFG_TAPS_ROW0    = 3'd3,
        CFG_TAPS_ROW1    = 3'd4,
        CFG_TAPS_ROW2    = 3'd5,
        CFG_TAPS_ROW3    = 3'd6,
        CFG_TAPS_ROW4    = 3'd7
    } cfg_idx_t;

    // per-item control that travels along the arithmetic pipeline
    typedef struct packed {
        logic                  emit;
        logic                  last;
        logic [ROW_W-1:0]      row;
        logic [COL_OUT_W-1:0]  col;
        logic [MAX_KERNEL-1:0] rmask;
        logic [MAX_KERNEL-1:0] cmask;
    } tag_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] value;
        logic [ROW_W-1:0]           row;
        logic [COL_OUT_W-1:0]       col;
        logic                       last;
    } res_t;

endpackage

### rtl/core/ics2d_if.sv
// input and output stream interfaces of the convolution block
interface ics2d_in_if;
    logic                                     valid;
    logic                                     ready;
    logic                                     op;
    logic signed [ics2d_pkg::SAMPLE_W-1:0]    sample;

    modport source (output valid, output op, output sample, input ready);
    modport sink   (input valid, input op, input sample, output ready);
endinterface

interface ics2d_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [ics2d_pkg::RESULT_W-1:0]    result_value;
    logic [ics2d_pkg::ROW_W-1:0]              out_row;
    logic [ics2d_pkg::COL_OUT_W-1:0]          out_col;
    logic                                     frame_last;

    modport source (output valid, output result_value, output out_row, output out_col,
                    output frame_last, input ready);
    modport sink   (input valid, input result_value, input out_row, input out_col,
                    input frame_last, output ready);
endinterface

### rtl/core/ics2d_ram.sv
// generic single-clock ram, one write and one registered read port
module ics2d_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old word when the same entry is written
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/ics2d_mac.sv
// window shift register, tap products and adder tree
module ics2d_mac (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        shift_en,
    input  logic signed [ics2d_pkg::SAMPLE_W-1:0]       col_in [ics2d_pkg::MAX_KERNEL],
    input  ics2d_pkg::tag_t                             tag_in,
    input  logic [ics2d_pkg::KSIZE_REG_W-1:0]           k_eff,
    input  logic [ics2d_pkg::CFG_W-1:0]                 taps [ics2d_pkg::TAP_ROWS],
    output logic                                        res_valid,
    output ics2d_pkg::res_t                             res,
    output logic [ics2d_pkg::PEND_STAGES-1:0]           pend_emit
);

    localparam int MK = ics2d_pkg::MAX_KERNEL;
    localparam int SW = ics2d_pkg::SAMPLE_W;
    localparam int TW = ics2d_pkg::TAP_W;
    localparam int PW = ics2d_pkg::PROD_W;
    localparam int RW = ics2d_pkg::RSUM_W;
    localparam int OW = ics2d_pkg::RESULT_W;

    // win_reg[c][i]: column c (oldest first), row i of the window
    logic signed [SW-1:0] win_reg  [MK][MK];
    logic signed [PW-1:0] prod_reg [MK][MK];
    logic signed [PW-1:0] prod_next[MK][MK];
    logic signed [RW-1:0] rsum_reg [MK];
    logic signed [RW-1:0] rsum_next[MK];
    logic signed [OW-1:0] total;
    logic                 v2_reg, v3_reg, v4_reg;
    ics2d_pkg::tag_t      t2_reg, t3_reg, t4_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            for (int c = 0; c < MK - 1; c++)
            begin
                win_reg[c] <= win_reg[c+1];
            end
            win_reg[MK-1] <= col_in;
        end
        t2_reg   <= tag_in;
        t3_reg   <= t2_reg;
        t4_reg   <= t3_reg;
        prod_reg <= prod_next;
        rsum_reg <= rsum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= shift_en;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // the live kernel occupies the newest k_eff columns of the window
    always_comb
    begin
        logic signed [SW-1:0] sel;
        logic signed [TW-1:0] tap;
        for (int i = 0; i < MK; i++)
        begin
            for (int j = 0; j < MK; j++)
            begin
                sel = '0;
                for (int c = 0; c < MK; c++)
                begin
                    if (c == MK - int'(k_eff) + j)
                    begin
                        sel = win_reg[c][i];
                    end
                end
                tap = taps[i][TW*j +: TW];
                if (t2_reg.rmask[i] && t2_reg.cmask[j])
                begin
                    prod_next[i][j] = PW'(sel) * PW'(tap);
                end
                else
                begin
                    prod_next[i][j] = '0;
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < MK; i++)
        begin
            rsum_next[i] = '0;
            for (int j = 0; j < MK; j++)
            begin
                rsum_next[i] = rsum_next[i] + RW'(prod_reg[i][j]);
            end
        end
    end

    always_comb
    begin
        total = '0;
        for (int i = 0; i < MK; i++)
        begin
            total = total + OW'(rsum_reg[i]);
        end
    end

    assign res_valid = v4_reg && t4_reg.emit;
    assign res.value = total;
    assign res.row   = t4_reg.row;
    assign res.col   = t4_reg.col;
    assign res.last  = t4_reg.last;
    assign pend_emit = {v4_reg && t4_reg.emit, v3_reg && t3_reg.emit, v2_reg && t2_reg.emit};

endmodule

### rtl/core/ics2d_ofifo.sv
// result queue that decouples the pipeline from the output receiver
module ics2d_ofifo (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    input  ics2d_pkg::res_t                       push_data,
    output logic [ics2d_pkg::OFIFO_CNT_W-1:0]     count,
    ics2d_out_if.source                           out_ch
);

    localparam int DEPTH = ics2d_pkg::OFIFO_DEPTH;
    localparam int PTR_W = ics2d_pkg::OFIFO_PTR_W;
    localparam int CNT_W = ics2d_pkg::OFIFO_CNT_W;

    ics2d_pkg::res_t  entry_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pop;

    assign pop = out_ch.valid && out_ch.ready;

    always_comb
    begin
        wptr_next = push ? wptr_reg + PTR_W'(1) : wptr_reg;
        rptr_next = pop ? rptr_reg + PTR_W'(1) : rptr_reg;
        cnt_next  = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign count               = cnt_reg;
    assign out_ch.valid        = (cnt_reg != '0);
    assign out_ch.result_value = entry_reg[rptr_reg].value;
    assign out_ch.out_row      = entry_reg[rptr_reg].row;
    assign out_ch.out_col      = entry_reg[rptr_reg].col;
    assign out_ch.frame_last   = entry_reg[rptr_reg].last;

endmodule

### rtl/core/image_convolution_2d_same.sv
// Zero-padded same-size 2-d convolution over a raster-order sample stream.
// in_ch carries one item per transfer: op 0 is an image sample, op 1 a
// flush position; (k-1-k/2)*(width+1) flush items after the last sample
// drain the frame. Each item after that initial lag yields one output pixel
// on out_ch with its row, column and a frame_last flag on the final pixel;
// the frame positions then restart at zero.
// The configuration port writes width, height, kernel size and the five tap
// rows; write it only while no item is in flight.
// Throughput: one item per clock while in_ch.ready is high. The line store is
// one ram word per column holding the last six rows (largest kernel plus one);
// each item reads that word, merges its sample and writes it back the next
// cycle, with forwarding when the same column repeats.
// The pixel caused by an item passes the ram read, the window shift, the
// products, the row sums and the result queue before out_ch.valid rises for it.
// out_ch is fed from an 8-entry queue; input stays ready while the queue and
// in-flight results leave room, so a stalled receiver stops input after up
// to 8 pending results and nothing is lost.
// Reset clears positions and loads width 1024, height 1024, kernel 3 and
// zero taps; the line store needs no clearing.
module image_convolution_2d_same #(
    parameter int MAX_WIDTH = ics2d_pkg::MAX_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ics2d_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ics2d_pkg::CFG_W-1:0]         cfg_data,
    ics2d_in_if.sink                            in_ch,
    ics2d_out_if.source                         out_ch
);

    `include "image_convolution_2d_same_assert.svh"

    localparam int MK    = ics2d_pkg::MAX_KERNEL;
    localparam int RR    = ics2d_pkg::RING_ROWS;
    localparam int SLW   = ics2d_pkg::SLOT_W;
    localparam int SW    = ics2d_pkg::SAMPLE_W;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = CW + 1;
    localparam int RCW   = ics2d_pkg::ROW_CNT_W;
    localparam int RWD   = ics2d_pkg::ROW_W;
    localparam int MW    = RWD + 2;
    localparam int KW    = ics2d_pkg::KSIZE_REG_W;
    localparam int XW    = ics2d_pkg::WIDTH_REG_W;
    localparam int CNT_W = ics2d_pkg::OFIFO_CNT_W;

    // configuration
    logic [XW-1:0]                 width_reg;
    logic [RWD-1:0]                height_reg;
    logic [KW-1:0]                 ksize_reg;
    logic [ics2d_pkg::CFG_W-1:0]   taps_reg [ics2d_pkg::TAP_ROWS];

    logic [WW-1:0]  w_eff;
    logic [RWD-1:0] ht_eff;
    logic [KW-1:0]  k_eff;
    logic [KW-1:0]  half;
    logic [KW-1:0]  lag;

    // raster positions
    logic [RCW-1:0] in_row_reg, in_row_next;
    logic [CW-1:0]  in_col_reg, in_col_next;
    logic [SLW-1:0] in_ring_reg, in_ring_next;
    logic [RWD-1:0] em_row_reg, em_row_next;
    logic [CW-1:0]  em_col_reg, em_col_next;

    // accept-stage decode
    logic            accept;
    logic            we0;
    logic [SLW-1:0]  slot0 [MK];
    ics2d_pkg::tag_t tag0;

    // read-modify-write stage
    logic            s1_valid_reg;
    logic            s1_fwd_reg;
    logic            s1_we_reg;
    logic [CW-1:0]   s1_addr_reg;
    logic [SLW-1:0]  s1_wslot_reg;
    logic [SW-1:0]   s1_wdata_reg;
    logic [SLW-1:0]  s1_slot_reg [MK];
    ics2d_pkg::tag_t s1_tag_reg;

    logic [RR*SW-1:0]       ram_rdata;
    logic [RR*SW-1:0]       base_word;
    logic [RR*SW-1:0]       merged;
    logic [RR*SW-1:0]       merged_last_reg;
    logic signed [SW-1:0]   col_sel [MK];

    // result path
    logic                              res_valid;
    ics2d_pkg::res_t                   res;
    logic [ics2d_pkg::PEND_STAGES-1:0] pend_emit;
    logic [CNT_W-1:0]                  fifo_cnt;
    logic [CNT_W-1:0]                  pend_total;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= XW'(1024);
            height_reg <= RWD'(1024);
            ksize_reg  <= KW'(3);
            for (int r = 0; r < ics2d_pkg::TAP_ROWS; r++)
            begin
                taps_reg[r] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (ics2d_pkg::cfg_idx_t'(cfg_index))
                ics2d_pkg::CFG_IMAGE_WIDTH:  width_reg   <= cfg_data[XW-1:0];
                ics2d_pkg::CFG_IMAGE_HEIGHT: height_reg  <= cfg_data[RWD-1:0];
                ics2d_pkg::CFG_KERNEL_SIZE:  ksize_reg   <= cfg_data[KW-1:0];
                ics2d_pkg::CFG_TAPS_ROW0:    taps_reg[0] <= cfg_data;
                ics2d_pkg::CFG_TAPS_ROW1:    taps_reg[1] <= cfg_data;
                ics2d_pkg::CFG_TAPS_ROW2:    taps_reg[2] <= cfg_data;
                ics2d_pkg::CFG_TAPS_ROW3:    taps_reg[3] <= cfg_data;
                ics2d_pkg::CFG_TAPS_ROW4:    taps_reg[4] <= cfg_data;
                default:                     width_reg   <= width_reg;
            endcase
        end
    end

    // clamp the geometry into the supported range
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_reg);
        end
        ht_eff = (height_reg == '0) ? RWD'(1) : height_reg;
        if (ksize_reg == '0)
        begin
            k_eff = KW'(1);
        end
        else if (32'(ksize_reg) > MK)
        begin
            k_eff = KW'(MK);
        end
        else
        begin
            k_eff = ksize_reg;
        end
        half = k_eff >> 1;
        lag  = k_eff - KW'(1) - half;
    end

    assign pend_total = CNT_W'(s1_valid_reg && s1_tag_reg.emit) + CNT_W'($countones(pend_emit));
    assign in_ch.ready = (fifo_cnt + pend_total) < CNT_W'(ics2d_pkg::OFIFO_DEPTH);
    assign accept      = in_ch.valid && in_ch.ready;

    // decode of the item at the current input position
    always_comb
    begin
        int t;
        we0 = (in_row_reg < RCW'(ht_eff)) && (WW'(in_col_reg) < w_eff);
        for (int i = 0; i < MK; i++)
        begin
            t = int'(in_ring_reg) + RR - (int'(k_eff) - 1) + i;
            if (t >= RR)
            begin
                t = t - RR;
            end
            if (t >= RR)
            begin
                t = t - RR;
            end
            slot0[i] = SLW'(t);
        end
        tag0.emit = (in_row_reg > RCW'(lag)) ||
                    ((in_row_reg == RCW'(lag)) && (WW'(in_col_reg) >= WW'(lag)));
        // with a single column the lag columns count as whole rows too
        if (w_eff == WW'(1))
        begin
            tag0.emit = in_row_reg >= (RCW'(lag) + RCW'(lag));
        end
        tag0.last = ((MW'(em_row_reg) + MW'(1)) >= MW'(ht_eff)) &&
                    ((WW'(em_col_reg) + WW'(1)) >= w_eff);
        tag0.row  = em_row_reg;
        tag0.col  = ics2d_pkg::COL_OUT_W'(em_col_reg);
        for (int i = 0; i < MK; i++)
        begin
            // window row em_row - half + i lies inside the frame
            tag0.rmask[i] = (i < int'(k_eff)) &&
                            ((MW'(em_row_reg) + MW'(i)) >= MW'(half)) &&
                            ((MW'(em_row_reg) + MW'(i)) < (MW'(ht_eff) + MW'(half)));
            tag0.cmask[i] = (i < int'(k_eff)) &&
                            ((WW'(em_col_reg) + WW'(i)) >= WW'(half)) &&
                            ((WW'(em_col_reg) + WW'(i)) < (w_eff + WW'(half)));
        end
    end

    // position counters
    always_comb
    begin
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        in_ring_next = in_ring_reg;
        em_row_next  = em_row_reg;
        em_col_next  = em_col_reg;
        if (accept)
        begin
            if (tag0.emit && tag0.last)
            begin
                in_row_next  = '0;
                in_col_next  = '0;
                in_ring_next = '0;
                em_row_next  = '0;
                em_col_next  = '0;
            end
            else
            begin
                if ((WW'(in_col_reg) + WW'(1)) >= w_eff)
                begin
                    in_col_next  = '0;
                    in_row_next  = (in_row_reg == '1) ? in_row_reg : in_row_reg + RCW'(1);
                    in_ring_next = (in_ring_reg == SLW'(RR - 1)) ? '0 :
                                   in_ring_reg + SLW'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + CW'(1);
                end
                if (tag0.emit)
                begin
                    if ((WW'(em_col_reg) + WW'(1)) >= w_eff)
                    begin
                        em_col_next = '0;
                        em_row_next = em_row_reg + RWD'(1);
                    end
                    else
                    begin
                        em_col_next = em_col_reg + CW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_ring_reg  <= '0;
            em_row_reg   <= '0;
            em_col_reg   <= '0;
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end
        else
        begin
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            in_ring_reg  <= in_ring_next;
            em_row_reg   <= em_row_next;
            em_col_reg   <= em_col_next;
            s1_valid_reg <= accept;
            // the item ahead writes this column in the cycle this one reads it
            s1_fwd_reg   <= accept && s1_valid_reg && (s1_addr_reg == in_col_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_we_reg    <= we0;
            s1_addr_reg  <= in_col_reg;
            s1_wslot_reg <= in_ring_reg;
            s1_wdata_reg <= in_ch.op ? '0 : in_ch.sample;
            s1_slot_reg  <= slot0;
            s1_tag_reg   <= tag0;
        end
        if (s1_valid_reg)
        begin
            merged_last_reg <= merged;
        end
    end

    ics2d_ram #(
        .WIDTH (RR * SW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_valid_reg && s1_we_reg),
        .waddr (s1_addr_reg),
        .wdata (merged),
        .raddr (in_col_reg),
        .rdata (ram_rdata)
    );

    // merge the new sample into its ring row and pick the window column
    always_comb
    begin
        base_word = s1_fwd_reg ? merged_last_reg : ram_rdata;
        merged    = base_word;
        if (s1_we_reg)
        begin
            for (int r = 0; r < RR; r++)
            begin
                if (SLW'(r) == s1_wslot_reg)
                begin
                    merged[SW*r +: SW] = s1_wdata_reg;
                end
            end
        end
        for (int i = 0; i < MK; i++)
        begin
            col_sel[i] = '0;
            for (int r = 0; r < RR; r++)
            begin
                if (SLW'(r) == s1_slot_reg[i])
                begin
                    col_sel[i] = merged[SW*r +: SW];
                end
            end
        end
    end

    ics2d_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (s1_valid_reg),
        .col_in    (col_sel),
        .tag_in    (s1_tag_reg),
        .k_eff     (k_eff),
        .taps      (taps_reg),
        .res_valid (res_valid),
        .res       (res),
        .pend_emit (pend_emit)
    );

    ics2d_ofifo u_ofifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .count     (fifo_cnt),
        .out_ch    (out_ch)
    );

    `ICS2D_ASSERT_IMP(a_ring_range, 1'b1, in_ring_reg < SLW'(RR), "ring row pointer out of range")
    `ICS2D_ASSERT_NXT(a_frame_restart, accept && tag0.emit && tag0.last, (in_row_reg == '0) && (in_col_reg == '0) && (em_row_reg == '0) && (em_col_reg == '0), "positions not cleared after frame end")
    `ICS2D_ASSERT_IMP(a_fwd_source, s1_valid_reg && s1_fwd_reg, $past(s1_valid_reg), "forwarding without a preceding write")

endmodule

### tb/image_convolution_2d_same_tb.sv
// testbench of the zero-padded same-size 2-d convolution block, with its own pixel predictor
module image_convolution_2d_same_tb;
    import ics2d_pkg::*;

    localparam int TAPS_RANDOM   = 0;
    localparam int TAPS_MAX      = 1;
    localparam int TAPS_MIN      = 2;
    localparam int ROW_LIMIT     = 32'h0FFF_FFFF;
    localparam int SETTLE_CYCLES = 12;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    ics2d_in_if  in_ch();
    ics2d_out_if out_ch();

    image_convolution_2d_same uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // predictor state
    logic [WIDTH_REG_W-1:0] width_reg;
    logic [ROW_W-1:0]       height_reg;
    logic [KSIZE_REG_W-1:0] ksize_reg;
    logic [CFG_W-1:0]       tap_rows [TAP_ROWS];
    shortint                line_mem [RING_ROWS][MAX_WIDTH];
    int unsigned            in_row, in_col, px_row, px_col;

    res_t pixel_q[$];
    int   errors;
    int   items_sent;
    int   pixels_seen;
    int   frames_done;
    int   hold_cycles;
    bit   in_gaps_on;
    bit   out_stalls_on;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void eff_geometry(output int w, output int ht, output int k);
        w  = width_reg;
        ht = height_reg;
        k  = ksize_reg;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (ht < 1) ht = 1;
        if (k < 1) k = 1;
        if (k > MAX_KERNEL) k = MAX_KERNEL;
    endfunction

    // advances the predictor by one item; returns 1 when a pixel is due
    function automatic bit predict_pixel(input bit op, input logic signed [SAMPLE_W-1:0] s,
                                         output res_t px);
        int w, ht, k, half, lag, r, c;
        longint pos, lag_items, acc;
        logic signed [TAP_W-1:0] tap;
        bit last;
        eff_geometry(w, ht, k);
        half = k / 2;
        lag  = k - 1 - half;
        px   = '0;
        if (in_row < ht && in_col < w)
            line_mem[in_row % RING_ROWS][in_col] = op ? 16'sd0 : s;
        pos       = longint'(in_row) * w + in_col;
        lag_items = longint'(lag) * w + lag;
        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            if (in_row < ROW_LIMIT) in_row++;
        end
        if (pos < lag_items)
            return 1'b0;
        acc = 0;
        for (int i = 0; i < k; i++)
        begin
            r = int'(px_row) - half + i;
            if (r < 0 || r >= ht) continue;
            for (int j = 0; j < k; j++)
            begin
                c = int'(px_col) - half + j;
                if (c < 0 || c >= w) continue;
                tap = tap_rows[i][TAP_W*j +: TAP_W];
                acc += longint'(line_mem[r % RING_ROWS][c]) * longint'(tap);
            end
        end
        last = (px_row + 1 >= ht) && (px_col + 1 >= w);
        px.value = acc[RESULT_W-1:0];
        px.row   = px_row[ROW_W-1:0];
        px.col   = px_col[COL_OUT_W-1:0];
        px.last  = last;
        if (last)
        begin
            in_row = 0;
            in_col = 0;
            px_row = 0;
            px_col = 0;
        end
        else
        begin
            px_col++;
            if (px_col >= w)
            begin
                px_col = 0;
                px_row++;
            end
        end
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // receiver: random stalls plus long hold-offs counted here
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (out_stalls_on && $urandom_range(0, 7) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            pixels_seen++;
            if (pixel_q.size() == 0)
                report("unexpected pixel row", out_ch.out_row, -1);
            else
            begin
                want = pixel_q.pop_front();
                if (out_ch.result_value !== want.value)
                    report("result_value", out_ch.result_value, want.value);
                if (out_ch.out_row !== want.row)
                    report("out_row", out_ch.out_row, want.row);
                if (out_ch.out_col !== want.col)
                    report("out_col", out_ch.out_col, want.col);
                if (out_ch.frame_last !== want.last)
                    report("frame_last", out_ch.frame_last, want.last);
                if (want.last)
                    frames_done++;
            end
        end
    end

    // called at a clock edge; returns at the edge of the transfer
    task automatic send_item(input bit op, input logic signed [SAMPLE_W-1:0] s);
        int gap;
        res_t px;
        gap = (in_gaps_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.op     <= op;
        in_ch.sample <= s;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        items_sent++;
        if (predict_pixel(op, s, px))
            pixel_q.push_back(px);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        wait (pixel_q.size() == 0);
        @(posedge clk);
    endtask

    task automatic configure(input int w, input int ht, input int k, input int tap_mode);
        logic [CFG_W-1:0] v;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        for (int idx = 0; idx < 8; idx++)
        begin
            case (cfg_idx_t'(idx))
                CFG_IMAGE_WIDTH:  v = CFG_W'(w);
                CFG_IMAGE_HEIGHT: v = CFG_W'(ht);
                CFG_KERNEL_SIZE:  v = CFG_W'(k);
                default:
                begin
                    if (tap_mode == TAPS_MAX)
                        v = {5{12'h7FF}};
                    else if (tap_mode == TAPS_MIN)
                        v = {5{12'h800}};
                    else
                        v = CFG_W'({$urandom, $urandom});
                end
            endcase
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(idx);
            cfg_data  <= v;
            case (cfg_idx_t'(idx))
                CFG_IMAGE_WIDTH:  width_reg = v[WIDTH_REG_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg = v[ROW_W-1:0];
                CFG_KERNEL_SIZE:  ksize_reg = v[KSIZE_REG_W-1:0];
                default:          tap_rows[idx - CFG_TAPS_ROW0] = v;
            endcase
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // one whole frame plus the trailing positions; pause_at < 0 means no pause
    task automatic run_frame(input int pause_at);
        int w, ht, k, lag, frame_items, total;
        bit op;
        eff_geometry(w, ht, k);
        lag = k - 1 - k / 2;
        frame_items = w * ht;
        total = frame_items + lag * w + lag;
        for (int p = 0; p < total; p++)
        begin
            if (p == pause_at)
                wait_drained();
            // samples past the frame end act as flushes
            op = (p < frame_items) ? ($urandom_range(0, 15) == 0) : $urandom_range(0, 1);
            send_item(op, pick_sample());
        end
    endtask

    task automatic test_directed();
        in_gaps_on = 1'b0;
        out_stalls_on = 1'b0;
        configure(4, 3, 3, TAPS_RANDOM);
        run_frame(-1);
        configure(1, 1, 1, TAPS_MAX);
        send_item(1'b0, 16'sh7FFF);
        configure(1, 2, 5, TAPS_MIN);
        run_frame(-1);
        configure(2, 2, 5, TAPS_MAX);
        run_frame(-1);
    endtask

    task automatic test_register_clamps();
        in_gaps_on = 1'b1;
        out_stalls_on = 1'b1;
        configure(0, 0, 7, TAPS_RANDOM);
        run_frame(-1);
        configure(3, 2, 0, TAPS_RANDOM);
        run_frame(-1);
        configure(5, 3, 6, TAPS_RANDOM);
        run_frame(-1);
    endtask

    // width register above the limit, clamped to the full line length
    task automatic test_max_width();
        in_gaps_on = 1'b0;
        out_stalls_on = 1'b1;
        configure(2047, 1, 2, TAPS_RANDOM);
        run_frame(-1);
    endtask

    task automatic test_backpressure();
        configure(7, 4, 5, TAPS_RANDOM);
        in_gaps_on = 1'b0;
        out_stalls_on = 1'b0;
        hold_cycles = 300;
        run_frame(-1);
        in_gaps_on = 1'b1;
        run_frame(20);
    endtask

    task automatic test_random_frames();
        int target;
        target = items_sent + 800;
        while (items_sent < target)
        begin
            configure($urandom_range(1, 16), $urandom_range(1, 8), $urandom_range(0, 7),
                      TAPS_RANDOM);
            repeat ($urandom_range(1, 3))
            begin
                in_gaps_on = $urandom_range(0, 3) != 0;
                out_stalls_on = $urandom_range(0, 3) != 0;
                run_frame($urandom_range(0, 3) == 0 ? $urandom_range(0, 30) : -1);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.op = 1'b0;
        in_ch.sample = '0;
        errors = 0;
        items_sent = 0;
        pixels_seen = 0;
        frames_done = 0;
        hold_cycles = 0;
        in_gaps_on = 1'b0;
        out_stalls_on = 1'b0;
        width_reg = 11'd1024;
        height_reg = 16'd1024;
        ksize_reg = 3'd3;
        for (int i = 0; i < TAP_ROWS; i++)
            tap_rows[i] = '0;
        in_row = 0;
        in_col = 0;
        px_row = 0;
        px_col = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_register_clamps();
        test_max_width();
        test_backpressure();
        test_random_frames();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("sent %0d items, checked %0d pixels over %0d frames", items_sent,
                 pixels_seen, frames_done);
        $display("kernels 1..5 with clamped registers, widths up to %0d, flush and stall mixes",
                 MAX_WIDTH);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
